### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the sequence queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define SMRQ_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("smrq assertion failed");

`define SMRQ_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("smrq assertion failed");

`else

`define SMRQ_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)

`define SMRQ_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

### sv/smrq_pkg.sv
// ----------------------------------------------------------------------------
// smrq_pkg
// Types, constants and helper functions of the shared sequence queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smrq_pkg;

  localparam int RING_DEPTH_DEF  = 16;
  localparam int MAX_READERS_DEF = 4;

  localparam int CODE_W     = 3;
  localparam int COLOUR_W   = 4;
  localparam int RCOUNT_W   = 3;
  localparam int READER_W   = 2;
  localparam int RAND_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int RD_CNT_W   = 5;

  localparam logic [COLOUR_W-1:0] MAX_COLOURS = 4'd8;
  localparam logic [COLOUR_W-1:0] MIN_COLOURS = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_READER_COUNT = 1'b0,
    CFG_COLOUR_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_TAKE  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD_LO,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic adv;
  } rem_ctrl_t;

  // Eight restoring remainder steps, one input bit per step, most significant first.
  function automatic logic [COLOUR_W-1:0] mod_step8(
    input logic [COLOUR_W-1:0] rem_in,
    input logic [7:0]          bits,
    input logic [COLOUR_W-1:0] div
  );
    logic [COLOUR_W:0]   t;
    logic [COLOUR_W-1:0] r;
    r = rem_in;
    for (int i = 7; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, div}) begin
        t = t - {1'b0, div};
      end
      r = t[COLOUR_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/smrq_ram.sv
// ----------------------------------------------------------------------------
// smrq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/smrq_rem.sv
// ----------------------------------------------------------------------------
// smrq_rem
// Two-step remainder unit: random value modulo the colour count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smrq_rem (
  input  wire logic                                clk,
  input  wire smrq_pkg::rem_ctrl_t                 ctrl,
  input  wire logic [smrq_pkg::RAND_W-1:0]         rnd,
  input  wire logic [smrq_pkg::COLOUR_W-1:0]       div,
  output logic      [smrq_pkg::CODE_W-1:0]         rem
);

  logic [smrq_pkg::COLOUR_W-1:0] rem_r;
  logic [7:0]                    lo_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem_r <= smrq_pkg::mod_step8('0, rnd[15:8], div);
      lo_r  <= rnd[7:0];
    end else if (ctrl.adv) begin
      rem_r <= smrq_pkg::mod_step8(rem_r, lo_r, div);
    end
  end

  assign rem = rem_r[smrq_pkg::CODE_W-1:0];

endmodule

`default_nettype wire

### sv/shared_multi_reader_sequence_queue_top.sv
// ----------------------------------------------------------------------------
// shared_multi_reader_sequence_queue_top
// Several readers draw type codes from one shared sequence kept in a ring.
//
// Input channel (in_valid/in_stall): one item is a take for a reader or a
// clear. Each item gives exactly one result on the out_ channel.
// A take appends a new code, the random value modulo the colour count, when
// the reader has reached the end of the sequence, returns the code at the
// reader's position and drops entries that all active readers have passed.
// A full ring refuses the append and reports overflow.
// An item passes the states ST_MOD_LO and ST_EXEC; the result is registered.
// A new item waits until the last is through, paced by the remainder unit (two
// steps of eight bits) and the registered read of the code RAM.
// The result is held in an output register, so a new item is taken while an
// earlier result waits; a held result stalls only the final step.
// Configuration writes (cfg_) are always ready and take effect at once. They
// must be made only while no item is in flight; the block does not enforce it.
// Reset empties the ring, zeroes all positions and sets the reader count
// to 2 and the colour count to 6; the code RAM itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module shared_multi_reader_sequence_queue_top #(
  parameter int RING_DEPTH  = smrq_pkg::RING_DEPTH_DEF,
  parameter int MAX_READERS = smrq_pkg::MAX_READERS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_operation,
  input  wire logic [smrq_pkg::READER_W-1:0]       in_reader,
  input  wire logic [smrq_pkg::RAND_W-1:0]         in_random_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [smrq_pkg::CODE_W-1:0]         out_type_code,
  output logic                                     out_overflow,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [smrq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [smrq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int LEN_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = LEN_W + 1;
  localparam int RDX_W  = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
  localparam int TREE_N = (MAX_READERS > 1) ? 2 ** $clog2(MAX_READERS) : 1;

  smrq_pkg::state_t                    state_r, state_nxt;
  smrq_pkg::rem_ctrl_t                 rem_ctrl;
  logic [smrq_pkg::RCOUNT_W-1:0]       reader_count_r;
  logic [smrq_pkg::COLOUR_W-1:0]       colour_count_r;
  logic [LEN_W-1:0]                    offsets_r [MAX_READERS];
  logic [LEN_W-1:0]                    offsets_nxt [MAX_READERS];
  logic [LEN_W-1:0]                    len_r, len_nxt;
  logic [IDX_W-1:0]                    base_r, base_nxt;
  smrq_pkg::op_t                       op_r;
  logic [smrq_pkg::READER_W-1:0]       rd_r;
  logic [LEN_W-1:0]                    pos_r, pos_nxt;
  logic [IDX_W-1:0]                    addr_r, addr_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [smrq_pkg::CODE_W-1:0]         out_code_r, out_code_nxt;
  logic                                out_ovf_r, out_ovf_nxt;
  logic                                ram_re, ram_we, exec_fire;
  logic [smrq_pkg::CODE_W-1:0]         ram_rdata, rem;
  logic [smrq_pkg::COLOUR_W-1:0]       colours_eff;
  logic [smrq_pkg::RD_CNT_W-1:0]       rc_ext, readers_eff;
  logic [MAX_READERS-1:0]              active;
  logic                                rd_act, append, ovf, take_ok;
  logic [LEN_W-1:0]                    off_sel, new_len, min_v;
  logic [SUM_W-1:0]                    slot_sum, base_sum;
  logic [LEN_W-1:0]                    upd [MAX_READERS];
  logic [LEN_W-1:0]                    leaf [TREE_N];
  logic [LEN_W-1:0]                    tree [2*TREE_N-1];
  logic [smrq_pkg::CODE_W-1:0]         code;

  assign cfg_ready     = 1'b1;
  assign in_stall      = (state_r != smrq_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_type_code = out_code_r;
  assign out_overflow  = out_ovf_r;

  always_comb begin
    if (colour_count_r == '0) begin
      colours_eff = smrq_pkg::MIN_COLOURS;
    end else if (colour_count_r > smrq_pkg::MAX_COLOURS) begin
      colours_eff = smrq_pkg::MAX_COLOURS;
    end else begin
      colours_eff = colour_count_r;
    end
  end

  always_comb begin
    rc_ext = smrq_pkg::RD_CNT_W'(reader_count_r);
    if (rc_ext == '0) begin
      readers_eff = smrq_pkg::RD_CNT_W'(1);
    end else if (rc_ext > smrq_pkg::RD_CNT_W'(MAX_READERS)) begin
      readers_eff = smrq_pkg::RD_CNT_W'(MAX_READERS);
    end else begin
      readers_eff = rc_ext;
    end
    for (int i = 0; i < MAX_READERS; i++) begin
      active[i] = (smrq_pkg::RD_CNT_W'(i) < readers_eff);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smrq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = smrq_pkg::ST_MOD_LO;
        end
      end
      smrq_pkg::ST_MOD_LO: begin
        state_nxt = smrq_pkg::ST_EXEC;
      end
      smrq_pkg::ST_EXEC: begin
        if (exec_fire) begin
          state_nxt = smrq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = smrq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rem_ctrl  = '0;
    ram_re    = 1'b0;
    exec_fire = 1'b0;
    unique case (state_r)
      smrq_pkg::ST_IDLE: begin
        rem_ctrl.load = in_valid;
      end
      smrq_pkg::ST_MOD_LO: begin
        rem_ctrl.adv = 1'b1;
        ram_re       = 1'b1;
      end
      smrq_pkg::ST_EXEC: begin
        exec_fire = !out_valid_r || !out_stall;
      end
      default: begin
        exec_fire = 1'b0;
      end
    endcase
  end

  smrq_rem u_rem (
    .clk  (clk),
    .ctrl (rem_ctrl),
    .rnd  (in_random_value),
    .div  (colours_eff),
    .rem  (rem)
  );

  always_comb begin
    off_sel = offsets_r[RDX_W'(rd_r)];
    pos_nxt = (off_sel > len_r) ? len_r : off_sel;
    slot_sum = SUM_W'(base_r) + SUM_W'(pos_nxt);
    if (slot_sum >= SUM_W'(RING_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(RING_DEPTH);
    end
    addr_nxt = slot_sum[IDX_W-1:0];
  end

  smrq_ram #(
    .WIDTH (smrq_pkg::CODE_W),
    .DEPTH (RING_DEPTH)
  ) u_code_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (rem),
    .re    (ram_re),
    .raddr (addr_nxt),
    .rdata (ram_rdata)
  );

  always_comb begin
    rd_act  = (smrq_pkg::RD_CNT_W'(rd_r) < readers_eff);
    append  = (pos_r == len_r);
    ovf     = append && (len_r == LEN_W'(RING_DEPTH));
    take_ok = (op_r == smrq_pkg::OP_TAKE) && rd_act && !ovf;
    ram_we  = exec_fire && take_ok && append;
    code    = append ? rem : ram_rdata;
    new_len = append ? len_r + LEN_W'(1) : len_r;

    for (int i = 0; i < MAX_READERS; i++) begin
      upd[i] = (RDX_W'(rd_r) == RDX_W'(i)) ? pos_r + LEN_W'(1) : offsets_r[i];
    end
    for (int i = 0; i < TREE_N; i++) begin
      leaf[i] = '1;
    end
    for (int i = 0; i < MAX_READERS; i++) begin
      if (active[i]) begin
        leaf[i] = upd[i];
      end
    end
    for (int i = 0; i < TREE_N; i++) begin
      tree[TREE_N-1+i] = leaf[i];
    end
    for (int k = TREE_N - 2; k >= 0; k--) begin
      tree[k] = (tree[2*k+1] < tree[2*k+2]) ? tree[2*k+1] : tree[2*k+2];
    end
    min_v = (tree[0] > new_len) ? new_len : tree[0];

    base_sum = SUM_W'(base_r) + SUM_W'(min_v);
    if (base_sum >= SUM_W'(RING_DEPTH)) begin
      base_sum = base_sum - SUM_W'(RING_DEPTH);
    end

    offsets_nxt = offsets_r;
    len_nxt     = len_r;
    base_nxt    = base_r;
    if (exec_fire) begin
      if (op_r == smrq_pkg::OP_CLEAR) begin
        for (int i = 0; i < MAX_READERS; i++) begin
          offsets_nxt[i] = '0;
        end
        len_nxt  = '0;
        base_nxt = '0;
      end else if (take_ok) begin
        for (int i = 0; i < MAX_READERS; i++) begin
          if (active[i]) begin
            offsets_nxt[i] = (upd[i] >= min_v) ? upd[i] - min_v : '0;
          end
        end
        len_nxt  = new_len - min_v;
        base_nxt = base_sum[IDX_W-1:0];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_code_nxt  = out_code_r;
    out_ovf_nxt   = out_ovf_r;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = take_ok ? code : '0;
      out_ovf_nxt   = (op_r == smrq_pkg::OP_TAKE) && rd_act && ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= smrq_pkg::ST_IDLE;
      reader_count_r <= smrq_pkg::RCOUNT_W'(2);
      colour_count_r <= smrq_pkg::COLOUR_W'(6);
      len_r          <= '0;
      base_r         <= '0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < MAX_READERS; i++) begin
        offsets_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
      offsets_r   <= offsets_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (smrq_pkg::cfg_reg_t'(cfg_index))
          smrq_pkg::CFG_READER_COUNT: begin
            reader_count_r <= cfg_wdata[smrq_pkg::RCOUNT_W-1:0];
          end
          smrq_pkg::CFG_COLOUR_COUNT: begin
            colour_count_r <= cfg_wdata[smrq_pkg::COLOUR_W-1:0];
          end
          default: begin
            colour_count_r <= colour_count_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rem_ctrl.load) begin
      op_r <= smrq_pkg::op_t'(in_operation);
      rd_r <= in_reader;
    end
    if (ram_re) begin
      pos_r  <= pos_nxt;
      addr_r <= addr_nxt;
    end
    out_code_r <= out_code_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  `SMRQ_ASSERT_NXT(a_accept_to_mod, clk, rst_n, in_valid && !in_stall, state_r == smrq_pkg::ST_MOD_LO)
  `SMRQ_ASSERT_NXT(a_mod_to_exec, clk, rst_n, state_r == smrq_pkg::ST_MOD_LO, state_r == smrq_pkg::ST_EXEC)
  `SMRQ_ASSERT_IMP(a_len_bound, clk, rst_n, 1'b1, len_r <= LEN_W'(RING_DEPTH))
  `SMRQ_ASSERT_IMP(a_ram_we_exec, clk, rst_n, ram_we, exec_fire && !ovf)
  `SMRQ_ASSERT_IMP(a_ovf_code_zero, clk, rst_n, out_valid && out_overflow, out_type_code == '0)

endmodule

`default_nettype wire
